### rtl/core/gbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gillespie binding step: shared definitions
// Widths, constants, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_BINS = 4096;
    localparam int ADDR_W   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int NB_W     = $clog2(MAX_BINS + 1);

    localparam int CNT_W    = 27;
    localparam int RATE_W   = 32;
    localparam int RND_W    = 32;
    localparam int BINF_W   = 12;
    localparam int BINS_W   = 13;
    localparam int CFG_W    = 32;
    localparam int CIDX_W   = 2;
    localparam int TS_W     = 64;

    localparam int PROD_W   = RATE_W + CNT_W;
    localparam int PS_W     = PROD_W + 1;
    localparam int ACC_W    = PS_W + ADDR_W;
    localparam int THR_W    = ACC_W + RND_W;
    localparam int THR_CH   = (ACC_W + 31) / 32;
    localparam int APAD_W   = THR_CH * 32;
    localparam int CMP_W    = (BINS_W > NB_W) ? BINS_W : NB_W;

    localparam int NL_W     = 38;
    localparam int L_W      = NL_W + 32;
    localparam int NUM_W    = L_W + 16;
    localparam int FRAC_N   = 32;
    localparam int K_W      = $clog2(NUM_W + 1);

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;
    localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(4096);

    typedef enum logic [CIDX_W-1:0] {
        CFG_TOTAL  = 2'd0,
        CFG_UNBIND = 2'd1,
        CFG_BINS   = 2'd2,
        CFG_SPARE  = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SUM, S_THR_MUL, S_THR_ADD, S_SEL_GO, S_SEL, S_UPD,
        S_NORM, S_SQ, S_LN0, S_LN1, S_LN2, S_DIV_INIT, S_DIV, S_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_STEP, OP_THR_MUL, OP_THR_ADD, OP_SEL_START,
        OP_UPDATE, OP_NORM, OP_SQ, OP_LN0, OP_LN1, OP_LN2, OP_DIV_INIT, OP_DIV,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic k_clr;
    } t_cmd;

    typedef struct packed {
        logic sweep_busy;
        logic clear_last;
        logic a0_zero;
        logic thr_last;
        logic norm_done;
        logic sq_last;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

### rtl/core/gillespie_binding_step_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gillespie binding step core
// Direct-method stochastic step over a table of binding bins.
// ----------------------------------------------------------------------------
// After reset the core clears its bound-count table, one bin per cycle, over
// all 4096 bins before it takes its first word; configuration writes are taken
// throughout. A load word is taken in the idle state, which the core keeps for
// the next word. For a step word, one pass over the bin tables sums the
// total propensity and a second pass finds the chosen reaction, each reading
// one bin per cycle through the read ports of the table RAMs, followed by the
// squaring steps for the 32 fraction bits of the logarithm and 86 steps of the
// bit-serial divider. A step with zero total propensity skips everything after
// the first pass. One word is worked on at a time; the result register lets a
// new word enter while the previous result is still waiting to be taken.
module gillespie_binding_step_core
    import gbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // bin_index[11:0], bind_rate[43:12], bound_count[70:44],
    // rand_time[102:71], rand_pick[134:103], zero pad[135]
    input  wire logic [135:0]      i_s_tdata,
    // mode[0]
    input  wire logic              i_s_tuser,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // reaction_bin[11:0], time_step[75:12], free_remaining[102:76], zero pad[103]
    output logic [103:0]           o_m_tdata,
    // is_unbinding[0], no_reaction[1]
    output logic [1:0]             o_m_tuser
);

    t_cmd              cmd;
    t_stat             stat;
    logic              in_acc;
    logic [BINF_W-1:0] reaction_bin;
    logic              is_unbinding;
    logic [TS_W-1:0]   time_step;
    logic [CNT_W-1:0]  free_remaining;
    logic              no_reaction;

    assign in_acc = i_s_tvalid && o_s_tready;

    gbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_acc   (in_acc),
        .i_in_mode  (i_s_tuser),
        .i_stat     (stat),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd)
    );

    gbs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_bin_index      (i_s_tdata[11:0]),
        .i_bind_rate      (i_s_tdata[43:12]),
        .i_bound_count    (i_s_tdata[70:44]),
        .i_rand_time      (i_s_tdata[102:71]),
        .i_rand_pick      (i_s_tdata[134:103]),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_reaction_bin   (reaction_bin),
        .o_is_unbinding   (is_unbinding),
        .o_time_step      (time_step),
        .o_free_remaining (free_remaining),
        .o_no_reaction    (no_reaction)
    );

    assign o_m_tdata = {1'b0, free_remaining, time_step, reaction_bin};
    assign o_m_tuser = {no_reaction, is_unbinding};

    // A new word is only taken once both bin sweeps have drained.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !stat.sweep_busy)
        else $error("input ready while a bin sweep is in flight");

    // A result is only written into a free output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.op == OP_OUT |-> stat.out_free)
        else $error("result overwrote a waiting output word");

    // A step without any reaction reports bin zero, binding and a saturated time.
    a_no_reaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |->
            (o_m_tuser[0] == 1'b0) && (o_m_tdata[11:0] == '0) && (&o_m_tdata[75:12]))
        else $error("no-reaction word carries a reaction");

endmodule
`default_nettype wire

### rtl/core/gbs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/core/gbs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gillespie binding step: controller
// Sequences the clearing pass, loads, the two bin sweeps, the logarithm,
// the divider and the result hand-off.
// ----------------------------------------------------------------------------
module gbs_ctrl
    import gbs_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_acc,
    input  wire logic  i_in_mode,
    input  wire t_stat i_stat,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.k_clr = 1'b0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_acc) begin
                    if (i_in_mode) begin
                        o_cmd.op    = OP_STEP;
                        o_cmd.k_clr = 1'b1;
                        n_state     = S_SUM;
                    end else begin
                        o_cmd.op = OP_LOAD;
                    end
                end
            end
            S_SUM: begin
                if (!i_stat.sweep_busy) begin
                    n_state = i_stat.a0_zero ? S_OUT : S_THR_MUL;
                end
            end
            S_THR_MUL: begin
                o_cmd.op = OP_THR_MUL;
                n_state  = S_THR_ADD;
            end
            S_THR_ADD: begin
                o_cmd.op = OP_THR_ADD;
                n_state  = i_stat.thr_last ? S_SEL_GO : S_THR_MUL;
            end
            S_SEL_GO: begin
                o_cmd.op = OP_SEL_START;
                n_state  = S_SEL;
            end
            S_SEL: begin
                if (!i_stat.sweep_busy) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.op = OP_UPDATE;
                n_state  = S_NORM;
            end
            S_NORM: begin
                if (i_stat.norm_done) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_SQ;
                end else begin
                    o_cmd.op = OP_NORM;
                end
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                if (i_stat.sq_last) n_state = S_LN0;
            end
            S_LN0: begin
                o_cmd.op = OP_LN0;
                n_state  = S_LN1;
            end
            S_LN1: begin
                o_cmd.op = OP_LN1;
                n_state  = S_LN2;
            end
            S_LN2: begin
                o_cmd.op = OP_LN2;
                n_state  = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                o_cmd.op    = OP_DIV_INIT;
                o_cmd.k_clr = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (i_stat.div_last) n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/gbs_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Gillespie binding step: datapath
// Bin tables, sweep pipeline, threshold multiply, logarithm, divider and
// the output register.
// ----------------------------------------------------------------------------
module gbs_dp
    import gbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_stat                  o_stat,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic [BINF_W-1:0] i_bin_index,
    input  wire logic [RATE_W-1:0] i_bind_rate,
    input  wire logic [CNT_W-1:0]  i_bound_count,
    input  wire logic [RND_W-1:0]  i_rand_time,
    input  wire logic [RND_W-1:0]  i_rand_pick,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [BINF_W-1:0]      o_reaction_bin,
    output logic                   o_is_unbinding,
    output logic [TS_W-1:0]        o_time_step,
    output logic [CNT_W-1:0]       o_free_remaining,
    output logic                   o_no_reaction
);

    // Configuration and counts
    logic [CNT_W-1:0]  r_total;
    logic [RATE_W-1:0] r_unbind;
    logic [BINS_W-1:0] r_bins;
    logic [CNT_W-1:0]  r_free;
    logic [RND_W-1:0]  r_r1, r_r2;

    // Sweep
    logic              r_issue, r_sel_mode;
    logic [NB_W-1:0]   r_cnt;
    logic              r_v1, r_v2, r_v3;
    logic [ADDR_W-1:0] r_bin1, r_bin2, r_bin3;
    logic [CNT_W-1:0]  r_bnd2, r_bnd3;
    logic [PROD_W-1:0] r_pb, r_pu, r_pb3;
    logic [PS_W-1:0]   r_ps;
    logic [ACC_W-1:0]  r_acc, r_cum;
    logic [THR_W-1:0]  r_thr;
    logic              r_found, r_sel_unb;
    logic [ADDR_W-1:0] r_sel_bin;
    logic [CNT_W-1:0]  r_sel_bnd;

    // Shared step counter and arithmetic
    logic [K_W-1:0]    r_k;
    logic [63:0]       r_mp;
    logic [31:0]       r_m;
    logic [4:0]        r_e;
    logic [63:0]       r_sq;
    logic [FRAC_N-1:0] r_frac;
    logic [L_W-1:0]    r_L;
    logic [NUM_W-1:0]  r_q;
    logic [ACC_W-1:0]  r_rem;

    logic [RATE_W-1:0] rate_q;
    logic [CNT_W-1:0]  bound_q;

    // Combinational helpers
    logic [CMP_W-1:0]  n_bins;
    logic [NB_W-1:0]   n_used;
    logic              load_ok;
    logic              rate_we, bound_we;
    logic [ADDR_W-1:0] bound_waddr;
    logic [CNT_W-1:0]  bound_wdata;
    logic [ACC_W-1:0]  cum_a, cum_b;
    logic              hit_a, hit_b;
    logic [31:0]       chunk;
    logic [32:0]       sq_t;
    logic [31:0]       sq_norm, m_op;
    logic [NL_W-1:0]   nl;
    logic [ACC_W:0]    rem_s, rem_d;
    logic              div_ge;
    logic [CNT_W-1:0]  upd_free, upd_bnd;
    logic [CNT_W-1:0]  load_free;

    assign n_bins  = (CMP_W'(r_bins) > CMP_W'(MAX_BINS)) ? CMP_W'(MAX_BINS) : CMP_W'(r_bins);
    assign n_used  = NB_W'(n_bins);
    assign load_ok = 32'(i_bin_index) < 32'(MAX_BINS);
    assign load_free = (r_free > i_bound_count) ? r_free - i_bound_count : '0;

    assign cum_a = r_cum + ACC_W'(r_pb3);
    assign cum_b = r_cum + ACC_W'(r_ps);
    assign hit_a = (cum_a != '0) && ({cum_a, 32'd0} >= r_thr);
    assign hit_b = (cum_b != '0) && ({cum_b, 32'd0} >= r_thr);

    assign chunk = 32'(APAD_W'(r_acc) >> {r_k, 5'd0});

    // Squared mantissa back into [1,2) with the integer bit split off.
    assign sq_t    = r_sq[63:31];
    assign sq_norm = sq_t[32] ? sq_t[32:1] : sq_t[31:0];
    assign m_op    = (r_k == '0) ? r_m : sq_norm;
    assign nl      = {6'd32 - {1'b0, r_e}, 32'd0} - NL_W'(r_frac);

    assign rem_s  = {r_rem, r_q[NUM_W-1]};
    assign rem_d  = rem_s - {1'b0, r_acc};
    assign div_ge = (rem_s >= {1'b0, r_acc});

    always_comb begin
        if (r_sel_unb) begin
            upd_bnd  = (r_sel_bnd != '0) ? r_sel_bnd - 1'b1 : r_sel_bnd;
            upd_free = (r_free < r_total) ? r_free + 1'b1 : r_free;
        end else begin
            upd_bnd  = (r_sel_bnd < r_total) ? r_sel_bnd + 1'b1 : r_sel_bnd;
            upd_free = (r_free != '0) ? r_free - 1'b1 : r_free;
        end
    end

    always_comb begin
        rate_we     = (i_cmd.op == OP_LOAD) && load_ok;
        bound_we    = 1'b0;
        bound_waddr = ADDR_W'(i_bin_index);
        bound_wdata = i_bound_count;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                bound_we    = 1'b1;
                bound_waddr = r_cnt[ADDR_W-1:0];
                bound_wdata = '0;
            end
            OP_LOAD: begin
                bound_we = load_ok;
            end
            OP_UPDATE: begin
                bound_we    = r_found;
                bound_waddr = r_sel_bin;
                bound_wdata = upd_bnd;
            end
            default: bound_we = 1'b0;
        endcase
    end

    gbs_ram #(.WIDTH(RATE_W), .DEPTH(MAX_BINS)) u_rate_ram (
        .i_clk   (i_clk),
        .i_we    (rate_we),
        .i_waddr (ADDR_W'(i_bin_index)),
        .i_wdata (i_bind_rate),
        .i_raddr (r_cnt[ADDR_W-1:0]),
        .o_rdata (rate_q)
    );

    gbs_ram #(.WIDTH(CNT_W), .DEPTH(MAX_BINS)) u_bound_ram (
        .i_clk   (i_clk),
        .i_we    (bound_we),
        .i_waddr (bound_waddr),
        .i_wdata (bound_wdata),
        .i_raddr (r_cnt[ADDR_W-1:0]),
        .o_rdata (bound_q)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_unbind    <= '0;
            r_bins      <= BINS_RESET;
            r_free      <= '0;
            r_issue     <= 1'b0;
            r_cnt       <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_found     <= 1'b0;
            r_sel_mode  <= 1'b0;
            r_k         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;

            if (i_cmd.k_clr) begin
                r_k <= '0;
            end else if (i_cmd.op == OP_THR_ADD || i_cmd.op == OP_SQ || i_cmd.op == OP_DIV) begin
                r_k <= r_k + 1'b1;
            end

            if (i_cmd.op == OP_STEP || i_cmd.op == OP_SEL_START) begin
                r_cnt      <= '0;
                r_issue    <= (n_used != '0);
                r_found    <= 1'b0;
                r_sel_mode <= (i_cmd.op == OP_SEL_START);
            end else begin
                if (r_issue || i_cmd.op == OP_CLEAR) r_cnt <= r_cnt + 1'b1;
                if (r_issue && ((r_cnt + 1'b1) == n_used || r_found)) r_issue <= 1'b0;
                if (r_sel_mode && r_v3 && !r_found && (hit_a || hit_b)) r_found <= 1'b1;
            end

            if (i_cmd.op == OP_LOAD && load_ok) r_free <= load_free;
            if (i_cmd.op == OP_UPDATE && r_found) r_free <= upd_free;

            if (i_cmd.op == OP_OUT) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            // Writing the total also refills the free pool.
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TOTAL: begin
                        r_total <= i_cfg_data[CNT_W-1:0];
                        r_free  <= i_cfg_data[CNT_W-1:0];
                    end
                    CFG_UNBIND: r_unbind <= i_cfg_data[RATE_W-1:0];
                    CFG_BINS:   r_bins   <= i_cfg_data[BINS_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_bin1 <= r_cnt[ADDR_W-1:0];
        r_bin2 <= r_bin1;
        r_bnd2 <= bound_q;
        r_pb   <= PROD_W'(rate_q) * PROD_W'(r_free);
        r_pu   <= PROD_W'(r_unbind) * PROD_W'(bound_q);
        r_bin3 <= r_bin2;
        r_bnd3 <= r_bnd2;
        r_pb3  <= r_pb;
        r_ps   <= PS_W'(r_pb) + PS_W'(r_pu);

        if (i_cmd.op == OP_STEP) begin
            r_r1  <= i_rand_time;
            r_r2  <= i_rand_pick;
            r_acc <= '0;
            r_thr <= '0;
        end else if (!r_sel_mode && r_v3) begin
            r_acc <= r_acc + ACC_W'(r_ps);
        end

        if (i_cmd.op == OP_SEL_START) begin
            r_cum <= '0;
        end else if (r_sel_mode && r_v3 && !r_found) begin
            r_cum <= cum_b;
            if (hit_a || hit_b) begin
                r_sel_bin <= r_bin3;
                r_sel_bnd <= r_bnd3;
                r_sel_unb <= !hit_a;
            end
        end

        unique case (i_cmd.op)
            OP_THR_MUL: r_mp  <= 64'(r_r2) * 64'(chunk);
            OP_THR_ADD: r_thr <= r_thr + (THR_W'(r_mp) << {r_k, 5'd0});
            OP_UPDATE: begin
                r_m <= (r_r1 == '0) ? 32'd1 : r_r1;
                r_e <= 5'd31;
            end
            OP_NORM: begin
                r_m <= {r_m[30:0], 1'b0};
                r_e <= r_e - 1'b1;
            end
            OP_SQ: begin
                r_sq <= 64'(m_op) * 64'(m_op);
                if (r_k != '0) r_frac <= {r_frac[FRAC_N-2:0], sq_t[32]};
            end
            OP_LN0: r_mp <= 64'(nl[31:0]) * 64'(LN2_Q32);
            OP_LN1: begin
                r_L  <= L_W'(r_mp);
                r_mp <= 64'(nl[NL_W-1:32]) * 64'(LN2_Q32);
            end
            OP_LN2: r_L <= r_L + (L_W'(r_mp) << 32);
            OP_DIV_INIT: begin
                r_q   <= NUM_W'(r_L) << 16;
                r_rem <= '0;
            end
            OP_DIV: begin
                r_rem <= div_ge ? rem_d[ACC_W-1:0] : rem_s[ACC_W-1:0];
                r_q   <= {r_q[NUM_W-2:0], div_ge};
            end
            OP_OUT: begin
                o_free_remaining <= r_free;
                if (r_acc == '0) begin
                    o_reaction_bin <= '0;
                    o_is_unbinding <= 1'b0;
                    o_time_step    <= '1;
                    o_no_reaction  <= 1'b1;
                end else begin
                    o_reaction_bin <= BINF_W'(r_sel_bin);
                    o_is_unbinding <= r_sel_unb;
                    o_time_step    <= (|r_q[NUM_W-1:TS_W]) ? '1 : r_q[TS_W-1:0];
                    o_no_reaction  <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.sweep_busy = r_issue | r_v1 | r_v2 | r_v3;
    assign o_stat.clear_last = (r_cnt[ADDR_W-1:0] == ADDR_W'(MAX_BINS - 1));
    assign o_stat.a0_zero    = (r_acc == '0);
    assign o_stat.thr_last   = (r_k == K_W'(THR_CH - 1));
    assign o_stat.norm_done  = r_m[31];
    assign o_stat.sq_last    = (r_k == K_W'(FRAC_N));
    assign o_stat.div_last   = (r_k == K_W'(NUM_W - 1));
    assign o_stat.out_free   = !o_out_valid || i_out_ready;

endmodule
`default_nettype wire

### bench/gbs_checker.sv
// ----------------------------------------------------------------------------
// Gillespie binding step checker
// Watches the configuration port and both stream channels. It keeps its own
// copy of the bin tables and the free pool, predicts each step result and
// compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gbs_checker
    import gbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire logic              i_s_tvalid,
    input  wire logic              i_s_tready,
    input  wire logic [135:0]      i_s_tdata,
    input  wire logic              i_s_tuser,
    input  wire logic              i_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire logic [103:0]      i_m_tdata,
    input  wire logic [1:0]        i_m_tuser,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_idle_results
);

    typedef struct {
        logic [BINF_W-1:0] bin;
        logic              unbind;
        logic [TS_W-1:0]   tstep;
        logic [CNT_W-1:0]  free_left;
        logic              idle_flag;
    } t_step_result;

    logic [RATE_W-1:0] bind_rates [MAX_BINS];
    logic [CNT_W-1:0]  bound_cnt  [MAX_BINS];
    logic [CNT_W-1:0]  free_pool;
    logic [CNT_W-1:0]  total_mol;
    logic [RATE_W-1:0] unbind_rate;
    logic [BINS_W-1:0] bins_used;

    t_step_result step_results_due[$];
    int fails;
    int no_reaction_seen;

    assign o_fail_count   = fails;
    assign o_pending      = step_results_due.size();
    assign o_idle_results = no_reaction_seen;

    // -log2(r / 2^32) in Q6.32, fraction bits by repeated squaring.
    function automatic logic [37:0] neg_log2_q32(logic [31:0] r);
        int e;
        logic [63:0] m;
        logic [31:0] frac;
        if (r == 0) r = 1;
        e = 31;
        while (r[e] == 1'b0) e--;
        m = 64'(r) << (31 - e);
        frac = '0;
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = {frac[30:0], 1'b0};
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (38'd32 << 32) - {6'(e), frac};
    endfunction

    function automatic t_step_result predict_step(logic [31:0] r_time, logic [31:0] r_pick);
        t_step_result res;
        logic [127:0] a0, thr, cum, prop, num, quo;
        int n;
        bit found;
        a0 = '0;
        cum = '0;
        found = 0;
        n = (bins_used > MAX_BINS) ? MAX_BINS : int'(bins_used);
        for (int b = 0; b < n; b++) begin
            a0 += 128'(bind_rates[b]) * 128'(free_pool);
            a0 += 128'(unbind_rate) * 128'(bound_cnt[b]);
        end
        res.bin = '0;
        res.unbind = 1'b0;
        res.idle_flag = 1'b0;
        if (a0 == 0) begin
            res.tstep = '1;
            res.free_left = free_pool;
            res.idle_flag = 1'b1;
            return res;
        end
        thr = a0 * 128'(r_pick);
        for (int k = 0; k < 2 * n && !found; k++) begin
            if (k % 2 == 1) prop = 128'(unbind_rate) * 128'(bound_cnt[k / 2]);
            else            prop = 128'(bind_rates[k / 2]) * 128'(free_pool);
            cum += prop;
            if (cum != 0 && (cum << 32) >= thr) begin
                found = 1;
                res.bin = BINF_W'(k / 2);
                res.unbind = (k % 2 == 1);
            end
        end
        if (found) begin
            if (res.unbind) begin
                if (bound_cnt[res.bin] > 0) bound_cnt[res.bin]--;
                if (free_pool < total_mol) free_pool++;
            end else begin
                if (free_pool > 0) free_pool--;
                if (bound_cnt[res.bin] < total_mol) bound_cnt[res.bin]++;
            end
        end
        num = (128'(neg_log2_q32(r_time)) * 128'(LN2_Q32)) << 16;
        quo = num / a0;
        res.tstep = (quo[127:64] != 0) ? '1 : quo[63:0];
        res.free_left = free_pool;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_step_result want, got;
        logic [CNT_W-1:0] cnt;
        if (!i_rst_n) begin
            foreach (bind_rates[b]) bind_rates[b] = '0;
            foreach (bound_cnt[b]) bound_cnt[b] = '0;
            free_pool = '0;
            total_mol = '0;
            unbind_rate = '0;
            bins_used = BINS_RESET;
            step_results_due.delete();
            fails = 0;
            no_reaction_seen = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_TOTAL: begin
                        total_mol = i_cfg_data[CNT_W-1:0];
                        free_pool = total_mol;
                    end
                    CFG_UNBIND: unbind_rate = i_cfg_data[RATE_W-1:0];
                    CFG_BINS:   bins_used = i_cfg_data[BINS_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == 1'b0) begin
                    cnt = i_s_tdata[70:44];
                    bind_rates[i_s_tdata[11:0]] = i_s_tdata[43:12];
                    bound_cnt[i_s_tdata[11:0]] = cnt;
                    free_pool = (free_pool > cnt) ? free_pool - cnt : '0;
                end else begin
                    step_results_due.push_back(
                        predict_step(i_s_tdata[102:71], i_s_tdata[134:103]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.bin = i_m_tdata[11:0];
                got.tstep = i_m_tdata[75:12];
                got.free_left = i_m_tdata[102:76];
                got.unbind = i_m_tuser[0];
                got.idle_flag = i_m_tuser[1];
                if (got.idle_flag) no_reaction_seen++;
                if (step_results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("checker: unexpected result word, bin %0d time %h",
                                 got.bin, got.tstep);
                end else begin
                    want = step_results_due.pop_front();
                    if (got.bin !== want.bin || got.unbind !== want.unbind ||
                        got.tstep !== want.tstep || got.free_left !== want.free_left ||
                        got.idle_flag !== want.idle_flag) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("checker: mismatch exp bin %0d unb %0d ts %h free %0d none %0d",
                                     want.bin, want.unbind, want.tstep, want.free_left,
                                     want.idle_flag);
                            $display("checker:          got bin %0d unb %0d ts %h free %0d none %0d",
                                     got.bin, got.unbind, got.tstep, got.free_left,
                                     got.idle_flag);
                        end
                    end
                end
            end
        end
    end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Gillespie binding step testbench
// Drives load and step words into the core under changing configurations and
// random handshake pressure; a checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import gbs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CIDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [135:0]      i_s_tdata = '0;
    logic              i_s_tuser = 1'b0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [103:0]      o_m_tdata;
    logic [1:0]        o_m_tuser;

    int fail_count, pending, idle_results;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int loads_sent = 0;
    int steps_sent = 0;
    int cycles = 0;
    int loaded_bins = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    gillespie_binding_step_core i_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tuser,
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tuser
    );

    gbs_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_fail_count(fail_count), .o_pending(pending), .o_idle_results(idle_results)
    );

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The word stays valid until the edge at which the core takes it.
    task automatic send_word(logic mode, logic [11:0] idx, logic [31:0] rate,
                             logic [26:0] cnt, logic [31:0] r_time, logic [31:0] r_pick);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= mode;
        i_s_tdata <= {1'b0, r_pick, r_time, cnt, rate, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (mode) steps_sent++;
        else loads_sent++;
    endtask

    task automatic load_bin(int idx, logic [31:0] rate, logic [26:0] cnt);
        send_word(1'b0, 12'(idx), rate, cnt, $urandom, $urandom);
        if (idx == loaded_bins) loaded_bins++;
    endtask

    task automatic step(logic [31:0] r_time, logic [31:0] r_pick);
        send_word(1'b1, 12'($urandom), $urandom, 27'($urandom), r_time, r_pick);
    endtask

    // Register writes happen only once the core has drained.
    task automatic write_reg(t_cfg_idx idx, logic [31:0] value);
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_frac();
        case ($urandom_range(9))
            0: return 32'hFFFF_FFFF;
            1: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n_items);
        int nb;
        nb = $urandom_range(1, 16);
        write_reg(CFG_TOTAL, $urandom_range(3) == 0 ? $urandom_range(27'h7FF_FFFF)
                                                    : $urandom_range(1, 5000));
        write_reg(CFG_UNBIND, $urandom_range(3) == 0 ? 0 : $urandom);
        write_reg(CFG_BINS, nb);
        for (int b = 0; b < nb; b++)
            load_bin(b, $urandom_range(4) == 0 ? 0 : $urandom, 27'($urandom_range(40)));
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(9) < 7) begin
                step(rand_frac(), rand_frac());
            end else if ($urandom_range(4) == 0) begin
                load_bin($urandom_range(4095), $urandom, 27'($urandom));
            end else begin
                load_bin($urandom_range(nb - 1), $urandom, 27'($urandom_range(100)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: four small bins with extreme rates and randoms.
        write_reg(CFG_TOTAL, 1000);
        write_reg(CFG_UNBIND, 32'h0001_0000);
        write_reg(CFG_BINS, 4);
        load_bin(0, 32'h0000_8000, 0);
        load_bin(1, 32'hFFFF_FFFF, 5);
        load_bin(2, 0, 0);
        load_bin(3, 1, 3);
        step(0, 0);
        step(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        step(1, 32'h8000_0000);
        step(32'h8000_0000, 1);
        // No bins in use gives a zero total propensity.
        write_reg(CFG_BINS, 0);
        step(32'h1234_5678, 32'h9ABC_DEF0);
        // A tiny propensity saturates the time step.
        write_reg(CFG_TOTAL, 1);
        write_reg(CFG_UNBIND, 0);
        write_reg(CFG_BINS, 1);
        load_bin(0, 1, 0);
        step(1, 32'hFFFF_FFFF);
        step(1, 1);
        // Largest counts and rates; the load drains the pool to zero.
        write_reg(CFG_TOTAL, 27'h7FF_FFFF);
        write_reg(CFG_UNBIND, 32'hFFFF_FFFF);
        write_reg(CFG_BINS, 2);
        load_bin(1, 32'hFFFF_FFFF, 27'h7FF_FFFF);
        step(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        step(1, 1);

        send_idle_pct = 33;
        recv_stall_pct = 84;
        random_phase(32);
        send_idle_pct = 84;
        recv_stall_pct = 33;
        random_phase(32);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_phase(32);

        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d load words and %0d step words; %0d steps saw no reaction.",
                 loads_sent, steps_sent, idle_results);
        $display("Configurations covered small and empty bin sets and extreme registers.");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
